/* sv/ka_pkg.sv */
// ----------------------------------------------------------------------------
// ka_pkg: shared types and a compare helper for the key argsort block
// Item and result layouts, store entry, controller command and status.
// ----------------------------------------------------------------------------
package ka_pkg;

    localparam int MAX_KEYS = 64;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    typedef struct packed {
        logic signed [63:0] key_high;
        logic        [63:0] key_low;
        logic        [15:0] tag;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic        [15:0] out_tag;
        logic signed [63:0] out_key_high;
        logic        [63:0] out_key_low;
        logic               overflow;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic              load_key;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_sel;
        logic [ADDR_W-1:0] wr_addr;
        logic              out_load;
        logic              out_overflow;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic key_gt;
    } status_t;

    // signed 128-bit compare: a strictly greater than b
    function automatic logic key_greater(entry_t a, entry_t b);
        logic [127:0] ua;
        logic [127:0] ub;
        ua = {~a.high[63], a.high[62:0], a.low};
        ub = {~b.high[63], b.high[62:0], b.low};
        return ua > ub;
    endfunction

endpackage

/* sv/ka_datapath.sv */
// ----------------------------------------------------------------------------
// ka_datapath: key store, held key, compare and result register
// Sorted store in one memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module ka_datapath
    import ka_pkg::*;
(
    input  logic      aclk,
    input  cmd_t      cmd,
    input  in_item_t  s_item,
    output status_t   status,
    output out_item_t m_item
);

    entry_t    mem [MAX_KEYS];
    entry_t    rdata_reg;
    entry_t    key_reg;
    entry_t    wdata;
    out_item_t out_reg;

    assign wdata = cmd.wr_sel ? rdata_reg : key_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg.high <= s_item.key_high;
            key_reg.low  <= s_item.key_low;
            key_reg.tag  <= s_item.tag;
        end
        if (cmd.out_load) begin
            out_reg.out_tag      <= rdata_reg.tag;
            out_reg.out_key_high <= rdata_reg.high;
            out_reg.out_key_low  <= rdata_reg.low;
            out_reg.overflow     <= cmd.out_overflow;
            out_reg.out_last     <= cmd.out_last;
        end
    end

    assign status.key_gt = key_greater(rdata_reg, key_reg);
    assign m_item        = out_reg;

endmodule

/* sv/ka_ctrl.sv */
// ----------------------------------------------------------------------------
// ka_ctrl: sequencer for insertion and emit
// Tracks fill count, insert position, emit index and the drop flag.
// ----------------------------------------------------------------------------
module ka_ctrl
    import ka_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_PLACE   = 6'b000100,
        ST_EMIT_RD = 6'b001000,
        ST_EMIT_LD = 6'b010000,
        ST_HOLD    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              dropped_reg, dropped_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  fill_dec;
    logic [CNT_W-1:0]  pos_dec;
    logic [CNT_W-1:0]  pos_dec2;
    logic [ADDR_W-1:0] idx_inc;
    logic              idx_end;
    logic              finish;

    assign fill_dec = fill_reg - CNT_W'(1);
    assign pos_dec  = pos_reg - CNT_W'(1);
    assign pos_dec2 = pos_reg - CNT_W'(2);
    assign idx_inc  = idx_reg + ADDR_W'(1);
    assign idx_end  = (CNT_W'(idx_reg) == fill_dec);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        cmd          = '0;
        finish       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    last_next    = s_last;
                    idx_next     = '0;
                    if (fill_reg == CNT_W'(MAX_KEYS)) begin
                        dropped_next = 1'b1;
                        state_next   = s_last ? ST_EMIT_RD : ST_IDLE;
                    end else begin
                        pos_next = fill_reg;
                        if (fill_reg == '0) begin
                            state_next = ST_PLACE;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = fill_dec[ADDR_W-1:0];
                            state_next  = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = pos_reg[ADDR_W-1:0];
                if (status.key_gt) begin
                    cmd.wr_sel = 1'b1;
                    pos_next   = pos_dec;
                    if (pos_dec == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = pos_dec2[ADDR_W-1:0];
                    end
                end else begin
                    finish = 1'b1;
                end
            end
            ST_PLACE: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = pos_reg[ADDR_W-1:0];
                finish      = 1'b1;
            end
            ST_EMIT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.out_load     = 1'b1;
                cmd.out_overflow = dropped_reg;
                cmd.out_last     = idx_end;
                state_next       = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_ready) begin
                    if (idx_end) begin
                        fill_next    = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next    = idx_inc;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_inc;
                        state_next  = ST_EMIT_LD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            fill_next  = fill_reg + CNT_W'(1);
            idx_next   = '0;
            state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            dropped_reg <= dropped_next;
            last_reg    <= last_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_HOLD);

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_KEYS))
        else $error("fill count above capacity");

    a_scan_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (pos_reg != '0))
        else $error("scan at position zero");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (fill_reg != '0))
        else $error("result beat with empty store");

    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && fill_reg == CNT_W'(MAX_KEYS)) |=> dropped_reg)
        else $error("dropped key not flagged");

endmodule

/* sv/key_argsort.sv */
// ----------------------------------------------------------------------------
// key_argsort: stable ascending sort of signed 128-bit keys with tags
// Insertion into a sorted store; emits the batch on the item marked last.
// Insert: stored keys greater than the new key move up one place, then the new
//   key is written; a key that arrives when the store is full is dropped.
// Emit: each result beat is held until m_ready; no new key is accepted until
//   the batch has been emitted. Synchronous active-low reset empties
//   the batch; store contents are not cleared.
// ----------------------------------------------------------------------------
module key_argsort
    import ka_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    cmd_t    cmd;
    status_t status;

    ka_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_item.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ka_datapath u_datapath (
        .aclk   (aclk),
        .cmd    (cmd),
        .s_item (s_item),
        .status (status),
        .m_item (m_item)
    );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the key argsort block
// Streams batches of signed 128-bit keys with tags through the input channel
// under bursty traffic and receiver back-pressure. A local sorted-store model
// predicts every emitted beat, including tie order and the overflow flag, and
// each result beat is compared field by field against it.
// ----------------------------------------------------------------------------
module testbench;
    import ka_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_ITEMS = 180;

    typedef struct packed {
        logic signed [63:0] high;
        logic        [63:0] low;
        logic        [15:0] tag;
    } stored_key_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    in_item_t    key_beats[$];
    out_item_t   sorted_results[$];
    stored_key_t sorted_store[MAX_KEYS];
    int          fill_count    = 0;
    logic        dropped       = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count   = 0;

    int   burst_left = 1;
    int   gap_left   = 0;
    logic hold_beat;
    logic next_valid;

    int   ready_mode  = 0;
    int   ready_left  = 0;
    int   ready_phase = 0;

    out_item_t want;

    key_argsort u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    function automatic logic key_above(stored_key_t e, logic signed [63:0] h, logic [63:0] l);
        logic signed [127:0] a;
        logic signed [127:0] b;
        a = {e.high, e.low};
        b = {h, l};
        return a > b;
    endfunction

    task automatic predict_item(input in_item_t it);
        int        pos;
        out_item_t r;
        if (fill_count < MAX_KEYS) begin
            pos = fill_count;
            while (pos > 0 && key_above(sorted_store[pos - 1], it.key_high, it.key_low)) begin
                sorted_store[pos] = sorted_store[pos - 1];
                pos--;
            end
            sorted_store[pos].high = it.key_high;
            sorted_store[pos].low  = it.key_low;
            sorted_store[pos].tag  = it.tag;
            fill_count++;
        end else begin
            dropped = 1'b1;
        end
        if (it.last) begin
            for (int i = 0; i < fill_count; i++) begin
                r.out_tag      = sorted_store[i].tag;
                r.out_key_high = sorted_store[i].high;
                r.out_key_low  = sorted_store[i].low;
                r.overflow     = dropped;
                r.out_last     = (i + 1 == fill_count);
                sorted_results.push_back(r);
            end
            fill_count = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic add_beat(input logic [63:0] h, input logic [63:0] l,
                            input logic [15:0] tg, input logic lst);
        in_item_t it;
        it.key_high = h;
        it.key_low  = l;
        it.tag      = tg;
        it.last     = lst;
        key_beats.push_back(it);
    endtask

    function automatic in_item_t random_key();
        in_item_t it;
        int       sel;
        int       sel2;
        sel  = $urandom_range(0, 3);
        sel2 = $urandom_range(0, 2);
        it.tag  = 16'($urandom);
        it.last = 1'b0;
        case ($urandom_range(0, 3))
            0, 1: begin
                it.key_high = {$urandom, $urandom};
                it.key_low  = {$urandom, $urandom};
            end
            2: begin
                it.key_high = (sel2 == 0) ? -64'sd1 : (sel2 == 1) ? 64'sd0 : 64'sd1;
                it.key_low  = (sel == 0) ? 64'd0 : (sel == 1) ? 64'd1 :
                              (sel == 2) ? '1 : 64'($urandom_range(0, 3));
            end
            default: begin
                it.key_high = (sel == 0) ? {1'b1, 63'd0} : (sel == 1) ? {1'b0, {63{1'b1}}} :
                              (sel == 2) ? 64'sd0 : -64'sd1;
                it.key_low  = (sel2 == 0) ? 64'd0 : (sel2 == 1) ? '1 : {$urandom, $urandom};
            end
        endcase
        return it;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // sender: bursts with random gaps, hold payload until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            hold_beat = s_valid;
            if (s_valid && s_ready) begin
                predict_item(s_item);
                hold_beat = 1'b0;
            end
            next_valid = hold_beat;
            if (!hold_beat) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (key_beats.size() > 0) begin
                    next_valid = 1'b1;
                    s_item <= key_beats.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver: stall pattern that changes mode every so often
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (ready_phase % 4) != 3;
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // check each result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sorted_results.size() == 0) begin
                $error("unexpected result beat: out_tag %h", m_item.out_tag);
                mismatch_count++;
            end else begin
                want = sorted_results.pop_front();
                compare_field("out_tag",      64'(want.out_tag),  64'(m_item.out_tag));
                compare_field("out_key_high", want.out_key_high, m_item.out_key_high);
                compare_field("out_key_low",  want.out_key_low,  m_item.out_key_low);
                compare_field("overflow",     64'(want.overflow), 64'(m_item.overflow));
                compare_field("out_last",     64'(want.out_last), 64'(m_item.out_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int       random_count;
        int       batch_idx;
        int       batch_len;
        in_item_t it;

        // single-key batches at both extremes
        add_beat({1'b1, 63'd0}, 64'd0, 16'h0000, 1'b1);
        add_beat({1'b0, {63{1'b1}}}, '1, 16'hffff, 1'b1);
        // mixed signs, extremes and a tie
        add_beat(64'd0, 64'd0, 16'h0010, 1'b0);
        add_beat('1, '1, 16'h0011, 1'b0);
        add_beat({1'b0, {63{1'b1}}}, '1, 16'h0012, 1'b0);
        add_beat({1'b1, 63'd0}, 64'd0, 16'h0013, 1'b0);
        add_beat(64'd0, 64'd1, 16'h0014, 1'b0);
        add_beat('1, 64'd0, 16'h0015, 1'b0);
        add_beat(64'd0, 64'd0, 16'h0016, 1'b0);
        add_beat(64'd0, '1, 16'h0017, 1'b1);
        // equal keys keep load order
        for (int i = 1; i <= 5; i++)
            add_beat(64'h0000_0000_1234_5678, 64'h8000_0000_0000_0000, 16'(i), i == 5);
        // same high word, descending low words
        add_beat(64'h0000_0000_0000_0005, 64'hffff_0000_0000_0000, 16'haaaa, 1'b0);
        add_beat(64'h0000_0000_0000_0005, 64'h0000_ffff_0000_0000, 16'h5555, 1'b0);
        add_beat(64'h0000_0000_0000_0005, 64'h0000_0000_ffff_0000, 16'h00ff, 1'b0);
        add_beat(64'h0000_0000_0000_0005, 64'h0000_0000_0000_ffff, 16'hff00, 1'b1);

        random_count = 0;
        batch_idx    = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (batch_idx == 3)
                batch_len = MAX_KEYS;
            else if (batch_idx == 7)
                batch_len = MAX_KEYS + $urandom_range(1, 6);
            else
                batch_len = $urandom_range(1, 12);
            for (int i = 0; i < batch_len; i++) begin
                it      = random_key();
                it.last = (i == batch_len - 1);
                key_beats.push_back(it);
            end
            random_count += batch_len;
            batch_idx++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (key_beats.size() > 0 || s_valid)
            @(posedge aclk);
        while (sorted_results.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
